// File: rtl/bas_pkg.sv
package bas_pkg;

    // Storage geometry
    localparam int SLOTS    = 16;
    localparam int KEY_BITS = 32;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);

    // Fixed port field widths
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_FW  = 4;
    localparam int COUNT_FW = 5;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // Outcome of one pass over the slots
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } scan_result_t;

endpackage

// File: rtl/bas_addr_ram.sv
module bas_addr_ram
    import bas_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [SLOT_W-1:0]   wr_addr,
    input  logic [KEY_BITS-1:0] wr_data,
    input  logic [SLOT_W-1:0]   rd_addr,
    output logic [KEY_BITS-1:0] rd_data
);

    logic [KEY_BITS-1:0] mem [SLOTS];
    logic [KEY_BITS-1:0] rd_data_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bas_scan_unit.sv
module bas_scan_unit
    import bas_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                cmp_en,
    input  logic [SLOT_W-1:0]   cmp_idx,
    input  logic                entry_valid,
    input  logic [KEY_BITS-1:0] entry_key,
    input  logic [KEY_BITS-1:0] key,
    output scan_result_t        result
);

    scan_result_t result_reg;
    scan_result_t result_next;
    logic         match;

    // Compare one slot per cycle against the key while cmp_en is high
    assign match = entry_valid && (entry_key == key);

    // Keep the lowest matching slot and the lowest free slot
    always_comb
    begin
        result_next = result_reg;
        if (clear)
        begin
            result_next = '0;
        end
        else if (cmp_en)
        begin
            if (match && !result_reg.hit)
            begin
                result_next.hit      = 1'b1;
                result_next.hit_slot = cmp_idx;
            end
            if (!entry_valid && !result_reg.free)
            begin
                result_next.free      = 1'b1;
                result_next.free_slot = cmp_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/bounded_address_set.sv
// Channel   | Direction | Signals                                  | Transfer when
// ----------+-----------+------------------------------------------+-----------------------
// command   | in        | start, kind, member_addr / busy          | start && !busy
// result    | out       | done, status, found, slot, member_count  | done (one cycle)
// config    | in        | cfg_valid, cfg_data / cfg_ready          | cfg_valid && cfg_ready
//
// After the accepting edge the command makes one pass over all SLOTS entries of the
// address RAM through a single comparator (ST_SCAN), then ST_DRAIN does the last compare
// behind the registered RAM read, then ST_RESULT applies the update, and done_reg rises
// from it. busy is high through these states; the result strobe appears once busy has
// dropped, in the same cycle in which a new command may already start.
// Reset (rst_n low, asynchronous) empties the set and sets capacity to 16.
// The receiver cannot stall: each result is strobed by done for one cycle only.
module bounded_address_set
    import bas_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [ADDR_W-1:0]   member_addr,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic                found,
    output logic [SLOT_FW-1:0]  slot,
    output logic [COUNT_FW-1:0] member_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SLOTS-1:0]    slot_valid_reg, slot_valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAP_W-1:0]    capacity_reg, capacity_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    logic                accept;
    logic                ram_wr_en;
    logic [KEY_BITS-1:0] ram_rd_data;
    logic [CNT_W-1:0]    cap_eff;
    scan_result_t        scan;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Saturate the configured capacity to the number of slots
    assign cap_eff = (int'(capacity_reg) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(capacity_reg);

    bas_addr_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (scan.free_slot),
        .wr_data (key_reg),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rd_data)
    );

    bas_scan_unit u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept),
        .cmp_en      (cmp_valid_reg),
        .cmp_idx     (cmp_idx_reg),
        .entry_valid (slot_valid_reg[cmp_idx_reg]),
        .entry_key   (ram_rd_data),
        .key         (key_reg),
        .result      (scan)
    );

    // Sequence the scan and apply the operation at its end
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = scan_idx_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        slot_valid_next = slot_valid_reg;
        count_next      = count_reg;
        capacity_next   = capacity_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        ram_wr_en       = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            capacity_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    key_next      = member_addr[KEY_BITS-1:0];
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_valid_next = 1'b1;
                if (scan_idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                done_next   = 1'b1;
                found_next  = scan.hit;
                slot_next   = scan.hit ? scan.hit_slot : '0;
                status_next = STATUS_OK;
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (count_reg >= cap_eff)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else if (!scan.hit)
                        begin
                            if (scan.free)
                            begin
                                ram_wr_en                       = 1'b1;
                                slot_valid_next[scan.free_slot] = 1'b1;
                                count_next                      = count_reg + 1'b1;
                                slot_next                       = scan.free_slot;
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (scan.hit)
                        begin
                            slot_valid_next[scan.hit_slot] = 1'b0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // Lookup, and the unused code that behaves as one
                        if (!scan.hit)
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                endcase
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, set contents and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            slot_valid_reg <= '0;
            count_reg      <= '0;
            capacity_reg   <= CAP_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_idx_reg    <= cmp_idx_next;
            slot_valid_reg <= slot_valid_next;
            count_reg      <= count_next;
            capacity_reg   <= capacity_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign slot         = SLOT_FW'(slot_reg);
    assign member_count = COUNT_FW'(count_reg);

endmodule

// File: tb/sv/address_set_checker.sv
`timescale 1ns / 100ps

module address_set_checker
    import bas_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [ADDR_W-1:0]   member_addr,
    input  logic                done,
    input  logic [STATUS_W-1:0] status,
    input  logic                found,
    input  logic [SLOT_FW-1:0]  slot,
    input  logic [COUNT_FW-1:0] member_count,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CAP_W-1:0]    cfg_data,
    output int                  pending_results,
    output int                  fail_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [SLOT_FW-1:0]  slot;
        logic [COUNT_FW-1:0] count;
    } outcome_t;

    // Mirror of the registry
    logic [KEY_BITS-1:0] member_key [SLOTS];
    logic [SLOTS-1:0]    member_live;
    int                  member_total;
    int                  capacity;

    outcome_t outcome_q[$];
    outcome_t observed;
    outcome_t predicted;
    int       failures;

    assign fail_count = failures;

    // Apply one command to the mirror and return the result it must produce
    function automatic outcome_t apply_command(input logic [KIND_W-1:0] op,
                                               input logic [ADDR_W-1:0] addr);
        outcome_t            res;
        logic [KEY_BITS-1:0] key;
        int                  limit;
        bit                  hit;
        bit                  have_free;
        int                  hit_idx;
        int                  free_idx;
        key       = addr[KEY_BITS-1:0];
        limit     = (capacity > SLOTS) ? SLOTS : capacity;
        hit       = 1'b0;
        have_free = 1'b0;
        hit_idx   = 0;
        free_idx  = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!hit && member_live[i] && member_key[i] == key)
            begin
                hit     = 1'b1;
                hit_idx = i;
            end
            if (!have_free && !member_live[i])
            begin
                have_free = 1'b1;
                free_idx  = i;
            end
        end
        res.status = STATUS_OK;
        res.found  = hit;
        res.slot   = hit ? SLOT_FW'(hit_idx) : '0;
        case (op)
            KIND_INSERT:
            begin
                // full wins over a duplicate; a duplicate changes nothing
                if (member_total >= limit || (!hit && !have_free))
                    res.status = STATUS_FULL;
                else if (!hit)
                begin
                    member_key[free_idx]  = key;
                    member_live[free_idx] = 1'b1;
                    member_total++;
                    res.slot = SLOT_FW'(free_idx);
                end
            end
            KIND_DELETE:
            begin
                if (!hit)
                    res.status = STATUS_NOT_FOUND;
                else
                begin
                    member_live[hit_idx] = 1'b0;
                    if (member_total > 0)
                        member_total--;
                end
            end
            default:
            begin
                // lookup, and the unused code behaves the same
                if (!hit)
                    res.status = STATUS_NOT_FOUND;
            end
        endcase
        res.count = COUNT_FW'(member_total);
        return res;
    endfunction

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Retire results, then predict new transfers, then take config writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_live  = '0;
            member_total = 0;
            capacity     = int'(CAP_RESET);
            outcome_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (done)
            begin
                observed = {status, found, slot, member_count};
                if (outcome_q.size() == 0)
                    report_failure($sformatf(
                        "result with none pending: status %0d found %0d slot %0d count %0d",
                        observed.status, observed.found, observed.slot, observed.count));
                else
                begin
                    predicted = outcome_q.pop_front();
                    if (observed !== predicted)
                        report_failure($sformatf(
                            {"result mismatch: expected status %0d found %0d slot %0d ",
                             "count %0d, got status %0d found %0d slot %0d count %0d"},
                            predicted.status, predicted.found, predicted.slot,
                            predicted.count, observed.status, observed.found,
                            observed.slot, observed.count));
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_command(kind, member_addr));
            if (cfg_valid && cfg_ready)
                capacity = int'(cfg_data);
            pending_results <= outcome_q.size();
        end
    end

    initial
    begin
        failures = 0;
    end

endmodule

// File: tb/sv/tb_bounded_address_set.sv
`timescale 1ns / 100ps

module tb_bounded_address_set;
    import bas_pkg::*;

    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 24;
    localparam int STALL_LIMIT     = 2000;
    localparam int POOL_SIZE       = 20;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 153;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   member_addr;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [SLOT_FW-1:0]  slot;
    logic [COUNT_FW-1:0] member_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_data;

    int                  pending_results;
    int                  fail_count;
    int                  stall_cycles;
    bit                  steady_feed;
    logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bounded_address_set DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .member_addr  (member_addr),
        .done         (done),
        .status       (status),
        .found        (found),
        .slot         (slot),
        .member_count (member_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    address_set_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .member_addr     (member_addr),
        .done            (done),
        .status          (status),
        .found           (found),
        .slot            (slot),
        .member_count    (member_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    // End the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles + 1 >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Hold one command until its transfer, then idle for a random gap unless steady_feed is set
    task automatic issue_command(input logic [KIND_W-1:0] op,
                                 input logic [ADDR_W-1:0] addr);
        int gap;
        start       <= 1'b1;
        kind        <= op;
        member_addr <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = steady_feed ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and hold off until every result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                cap_plan [PHASES];
        int                insert_pct;
        int                delete_pct;
        int                roll;
        logic [KIND_W-1:0] op;
        logic [ADDR_W-1:0] addr;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        kind        <= KIND_INSERT;
        member_addr <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        steady_feed  = 1'b0;
        stall_cycles = 0;
        cap_plan = '{1, 0, 31, 16, 17, 8, 2, 16, 5, 12, 3, 16};
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, duplicates, absent keys, lowest free slot
        issue_command(KIND_INSERT, '0);
        issue_command(KIND_INSERT, '1);
        issue_command(KIND_INSERT, '0);
        issue_command(KIND_LOOKUP, '1);
        issue_command(KIND_UNUSED, '1);
        issue_command(KIND_LOOKUP, 32'h5A5A_5A5A);
        issue_command(KIND_DELETE, 32'h5A5A_5A5A);
        issue_command(KIND_DELETE, '0);
        issue_command(KIND_LOOKUP, '0);
        issue_command(KIND_INSERT, 32'h5A5A_5A5A);

        // Directed: full set, also for a key already present
        write_capacity(CAP_W'(2));
        issue_command(KIND_INSERT, '0);
        issue_command(KIND_INSERT, '1);
        issue_command(KIND_DELETE, 32'h5A5A_5A5A);
        issue_command(KIND_INSERT, '0);

        // Directed: zero capacity, then capacity above the slot count
        write_capacity(CAP_W'(0));
        issue_command(KIND_INSERT, 32'h1234_5678);
        issue_command(KIND_LOOKUP, '0);
        write_capacity(CAP_W'(31));
        issue_command(KIND_INSERT, 32'h1234_5678);

        // Random phases over a key pool small enough to hit often
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(CAP_W'(cap_plan[p]));
            insert_pct = $urandom_range(35, 70);
            delete_pct = $urandom_range(15, 35);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 3)
                    steady_feed = !steady_feed;
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                roll = $urandom_range(0, 99);
                if (roll < insert_pct)
                    op = KIND_INSERT;
                else if (roll < insert_pct + delete_pct)
                    op = KIND_DELETE;
                else if (roll < 96)
                    op = KIND_LOOKUP;
                else
                    op = KIND_UNUSED;
                // inserts stay in the pool so the set can drain again
                if (op != KIND_INSERT && $urandom_range(0, 99) < 15)
                    addr = $urandom;
                else
                    addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                issue_command(op, addr);
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: bounded_address_set.f
rtl/bas_pkg.sv
rtl/bas_addr_ram.sv
rtl/bas_scan_unit.sv
rtl/bounded_address_set.sv
tb/sv/address_set_checker.sv
tb/sv/tb_bounded_address_set.sv
